>>> rtl/core/vbd_pkg.sv
// vbd_pkg: shared types and constants of the vp8 boolean decoder
// depends on nothing; imported by the interfaces' users, controller and datapath
`default_nettype none

package vbd_pkg;

    // item command codes
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_START   = 2'd1,
        CMD_BOOL    = 2'd2,
        CMD_LITERAL = 2'd3
    } t_cmd;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REFILL,
        S_FETCH_RD,
        S_FETCH_WR,
        S_EMIT
    } t_state;

    // fixed constants of the bool coder
    localparam logic [7:0] PROB_HALF   = 8'h80;
    localparam logic [7:0] RANGE_INIT  = 8'd255;
    localparam logic [6:0] COUNT_INIT  = 7'h78;   // minus eight
    localparam logic [3:0] LIT_MAX     = 4'd8;
    localparam logic [3:0] BYTE_BITS   = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch a bool or literal item
        logic literal;   // captured item is a literal
        logic load;      // write one byte into the store
        logic start;     // reset decoder state
        logic decode;    // one bool decode step
        logic refill;    // size the refill and update the exhausted flag
        logic fetch_wr;  // merge the fetched byte into the window
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic lit_zero;     // offered literal has no bits
        logic refill_due;   // decode step leaves the window short
        logic last_bit;     // decode step in progress is the item's last
        logic remain_zero;  // no decode steps left for the item
        logic fetch_none;   // refill needs no byte
        logic fetch_last;   // byte being merged is the refill's last
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/core/vbd_intf.sv
// vbd_intf: valid/ready channels of the vp8 boolean decoder
// depends on nothing
`default_nettype none

interface vbd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] prob;
    logic [3:0] literal_bits;

    modport source (output valid, cmd, data_byte, last_byte, prob, literal_bits,
                    input ready);
    modport sink   (input valid, cmd, data_byte, last_byte, prob, literal_bits,
                    output ready);
endinterface

interface vbd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  decoded;
    logic [7:0]  range_now;
    logic [7:0]  value_top;
    logic [3:0]  bits_in_byte;
    logic [11:0] bytes_consumed;
    logic        past_end;

    modport source (output valid, decoded, range_now, value_top, bits_in_byte,
                    bytes_consumed, past_end, input ready);
    modport sink   (input valid, decoded, range_now, value_top, bits_in_byte,
                    bytes_consumed, past_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vbd_dpath.sv
// vbd_dpath: byte store, value window, range, bit count and pointers
// depends on vbd_pkg; driven by vbd_ctrl through t_dp_cmd
`default_nettype none

module vbd_dpath #(
    parameter int BUFFER_BYTES = 2048,
    parameter int WINDOW_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire vbd_pkg::t_dp_cmd     i_cmd,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_last_byte,
    input  wire logic [7:0]           i_prob,
    input  wire logic [3:0]           i_literal_bits,
    output vbd_pkg::t_dp_status       o_status,
    output logic [7:0]                o_decoded,
    output logic [7:0]                o_range_now,
    output logic [7:0]                o_value_top,
    output logic [3:0]                o_bits_in_byte,
    output logic [11:0]               o_bytes_consumed,
    output logic                      o_past_end
);
    import vbd_pkg::*;

    localparam int PW  = $clog2(BUFFER_BYTES + 1);
    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int SHW = $clog2(WINDOW_BITS);
    localparam int W   = WINDOW_BITS;
    localparam logic [PW-1:0] BUF_END = PW'(BUFFER_BYTES);
    localparam logic [8:0]    SH_BASE = 9'(WINDOW_BITS - 16);

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [W-1:0]  r_win,    n_win;
    logic [6:0]    r_bc,     n_bc;
    logic [7:0]    r_range,  n_range;
    logic [PW-1:0] r_rp,     n_rp;
    logic [PW-1:0] r_wp,     n_wp;
    logic [PW-1:0] r_dl,     n_dl;
    logic          r_exh,    n_exh;
    logic [3:0]    r_fetch,  n_fetch;
    logic [3:0]    r_remain, n_remain;
    logic [7:0]    r_prob,   n_prob;
    logic [7:0]    r_result, n_result;

    // decode step
    logic [7:0]    top;
    logic [15:0]   prod;
    logic [8:0]    split9;
    logic [7:0]    split;
    logic          bit_one;
    logic [7:0]    top_new;
    logic [7:0]    rng_new;
    logic [2:0]    norm;
    logic [7:0]    rng_norm;
    logic [W-1:0]  win_dec;
    logic [6:0]    bc_dec;

    // refill sizing and merge
    logic [8:0]    sh;
    logic [SHW-1:0] sh_amt;
    logic [3:0]    full;
    logic [PW-1:0] bytes_left;
    logic          more_than_full;
    logic [3:0]    fetch_cnt;
    logic [W-1:0]  byte_ext;

    // load
    logic          wp_room;
    logic [PW-1:0] wp_inc;
    logic [3:0]    lit_sat;
    logic [PW+11:0] rp_ext;

    function automatic logic [2:0] lead_zeros(input logic [7:0] v);
        logic [2:0] cnt;
        cnt = 3'd7;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                cnt = 3'(7 - k);
            end
        end
        return cnt;
    endfunction

    // split of the range and renormalisation
    always_comb begin
        top      = r_win[W-1 -: 8];
        prod     = (r_range - 8'd1) * r_prob;
        split9   = 9'd1 + {1'b0, prod[15:8]};
        split    = split9[7:0];
        bit_one  = (top >= split);
        top_new  = bit_one ? (top - split) : top;
        rng_new  = bit_one ? (r_range - split) : split;
        norm     = lead_zeros(rng_new);
        rng_norm = rng_new << norm;
        win_dec  = {top_new, r_win[W-9:0]} << norm;
        bc_dec   = r_bc - {4'd0, norm};
    end

    // refill sizing: shift of the next byte follows from the bit count
    always_comb begin
        sh             = SH_BASE - {{2{r_bc[6]}}, r_bc};
        sh_amt         = sh[SHW-1:0];
        full           = {1'b0, sh[5:3]} + 4'd1;
        bytes_left     = (r_dl > r_rp) ? (r_dl - r_rp) : '0;
        more_than_full = (PW'(full) < bytes_left);
        fetch_cnt      = more_than_full ? full : bytes_left[3:0];
        byte_ext       = {{(W-8){1'b0}}, r_rdata} << sh_amt;
    end

    always_comb begin
        wp_room = (r_wp < BUF_END);
        wp_inc  = wp_room ? (r_wp + PW'(1)) : r_wp;
        lit_sat = (i_literal_bits > LIT_MAX) ? LIT_MAX : i_literal_bits;
    end

    always_comb begin
        n_win    = r_win;
        n_bc     = r_bc;
        n_range  = r_range;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_dl     = r_dl;
        n_exh    = r_exh;
        n_fetch  = r_fetch;
        n_remain = r_remain;
        n_prob   = r_prob;
        n_result = r_result;
        if (i_cmd.load) begin
            n_wp = i_last_byte ? '0 : wp_inc;
            if (i_last_byte) begin
                n_dl = wp_inc;
            end
        end
        if (i_cmd.start) begin
            n_win   = '0;
            n_bc    = COUNT_INIT;
            n_range = RANGE_INIT;
            n_rp    = '0;
            n_exh   = 1'b0;
        end
        if (i_cmd.capture) begin
            n_remain = i_cmd.literal ? lit_sat : 4'd1;
            n_prob   = i_cmd.literal ? PROB_HALF : i_prob;
            n_result = '0;
        end
        if (i_cmd.decode) begin
            n_win    = win_dec;
            n_bc     = bc_dec;
            n_range  = rng_norm;
            n_remain = r_remain - 4'd1;
            n_result = {r_result[6:0], bit_one};
        end
        if (i_cmd.refill) begin
            n_exh   = !more_than_full;
            n_fetch = fetch_cnt;
        end
        if (i_cmd.fetch_wr) begin
            n_win   = r_win | byte_ext;
            n_bc    = r_bc + 7'd8;
            n_rp    = r_rp + PW'(1);
            n_fetch = r_fetch - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_bc     <= COUNT_INIT;
            r_range  <= RANGE_INIT;
            r_rp     <= '0;
            r_wp     <= '0;
            r_dl     <= '0;
            r_exh    <= 1'b0;
            r_fetch  <= '0;
            r_remain <= '0;
        end else begin
            r_win    <= n_win;
            r_bc     <= n_bc;
            r_range  <= n_range;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_dl     <= n_dl;
            r_exh    <= n_exh;
            r_fetch  <= n_fetch;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prob   <= n_prob;
        r_result <= n_result;
    end

    // byte store, registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wp_room) begin
            r_mem[r_wp[AW-1:0]] <= i_data_byte;
        end
        r_rdata <= r_mem[r_rp[AW-1:0]];
    end

    always_comb begin
        o_status.lit_zero    = (i_literal_bits == 4'd0);
        o_status.refill_due  = !r_exh && bc_dec[6];
        o_status.last_bit    = (r_remain == 4'd1);
        o_status.remain_zero = (r_remain == 4'd0);
        o_status.fetch_none  = (fetch_cnt == 4'd0);
        o_status.fetch_last  = (r_fetch == 4'd1);
    end

    assign rp_ext           = {12'd0, r_rp};
    assign o_decoded        = r_result;
    assign o_range_now      = r_range;
    assign o_value_top      = r_win[W-1 -: 8];
    assign o_bits_in_byte   = BYTE_BITS - {1'b0, r_bc[2:0]};
    assign o_bytes_consumed = rp_ext[11:0];
    assign o_past_end       = r_exh;

    // range stays normalised across every operation
    a_range_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_range[7])
        else $error("range left unnormalised");

    // a merge never runs with an empty fetch count
    a_fetch_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch_wr |-> (r_fetch != 4'd0))
        else $error("byte merge with no fetch pending");

    // fetching never overtakes the data length
    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch_wr |=> (r_rp <= r_dl))
        else $error("read pointer past data length");

    // a full refill leaves the bit count non-negative
    a_full_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fetch_wr && (r_fetch == 4'd1) && !r_exh) |=> !r_bc[6])
        else $error("refill left the window short");

endmodule

`default_nettype wire

>>> rtl/core/vbd_ctrl.sv
// vbd_ctrl: item sequencer of the vp8 boolean decoder
// depends on vbd_pkg; commands vbd_dpath through t_dp_cmd
`default_nettype none

module vbd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [1:0]           i_in_cmd,
    input  wire logic                 i_out_free,
    input  wire vbd_pkg::t_dp_status  i_status,
    output logic                      o_in_ready,
    output logic                      o_emit,
    output vbd_pkg::t_dp_cmd          o_cmd
);
    import vbd_pkg::*;

    t_state r_state, n_state;
    logic   r_job_start, n_job_start;
    logic   accept;
    t_cmd   item_cmd;
    t_state resume;

    assign item_cmd = t_cmd'(i_in_cmd);
    assign accept   = i_in_valid && (r_state == S_IDLE);

    // where a finished refill hands back to
    always_comb begin
        if (r_job_start) begin
            resume = S_IDLE;
        end else if (i_status.remain_zero) begin
            resume = S_EMIT;
        end else begin
            resume = S_DECODE;
        end
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_job_start = r_job_start;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (item_cmd)
                        CMD_LOAD: begin
                            n_state = S_IDLE;
                        end
                        CMD_START: begin
                            n_state     = S_REFILL;
                            n_job_start = 1'b1;
                        end
                        CMD_BOOL: begin
                            n_state     = S_DECODE;
                            n_job_start = 1'b0;
                        end
                        CMD_LITERAL: begin
                            n_state     = i_status.lit_zero ? S_EMIT : S_DECODE;
                            n_job_start = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DECODE: begin
                if (i_status.refill_due) begin
                    n_state = S_REFILL;
                end else if (i_status.last_bit) begin
                    n_state = S_EMIT;
                end
            end
            S_REFILL: begin
                n_state = i_status.fetch_none ? resume : S_FETCH_RD;
            end
            S_FETCH_RD: begin
                n_state = S_FETCH_WR;
            end
            S_FETCH_WR: begin
                n_state = i_status.fetch_last ? resume : S_FETCH_RD;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_emit         = (r_state == S_EMIT) && i_out_free;
        o_cmd.capture  = accept && ((item_cmd == CMD_BOOL) || (item_cmd == CMD_LITERAL));
        o_cmd.literal  = (item_cmd == CMD_LITERAL);
        o_cmd.load     = accept && (item_cmd == CMD_LOAD);
        o_cmd.start    = accept && (item_cmd == CMD_START);
        o_cmd.decode   = (r_state == S_DECODE);
        o_cmd.refill   = (r_state == S_REFILL);
        o_cmd.fetch_wr = (r_state == S_FETCH_WR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job_start <= n_job_start;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/vp8_bool_decoder.sv
// vp8_bool_decoder: top level of the vp8 boolean entropy decoder
// depends on vbd_pkg, vbd_intf, vbd_ctrl and vbd_dpath
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+--------------------------------------------
//   i_in    | in  | valid / ready | cmd, data_byte, last_byte, prob, literal_bits
//   o_out   | out | valid / ready | decoded, range_now, value_top, bits_in_byte,
//           |     |               | bytes_consumed, past_end
//
// items are taken only while the sequencer is idle; a load is written to the
// store as it is taken; a start runs a refill of b bytes into the window (up to 4)
// a bool runs the decode step then emits, with a refill in between when the
// window runs short; a literal of n bits repeats the decode step n times
// refill speed is set by the byte store's single registered read port
// reset is synchronous and needs no clearing pass; a stalled result sits in
// the output register while the next item is already taken and worked on
`default_nettype none

module vp8_bool_decoder #(
    parameter int BUFFER_BYTES = 2048,
    parameter int WINDOW_BITS  = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vbd_in_if.sink     i_in,
    vbd_out_if.source  o_out
);
    import vbd_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       emit;
    logic       out_free;

    // datapath views of the result fields
    logic [7:0]  dp_decoded;
    logic [7:0]  dp_range_now;
    logic [7:0]  dp_value_top;
    logic [3:0]  dp_bits_in_byte;
    logic [11:0] dp_bytes_consumed;
    logic        dp_past_end;

    // output register, parts the result side from the sequencer
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_decoded;
    logic [7:0]  r_range_now;
    logic [7:0]  r_value_top;
    logic [3:0]  r_bits_in_byte;
    logic [11:0] r_bytes_consumed;
    logic        r_past_end;

    // free when empty or when the held result is transferred this cycle
    assign out_free = !r_out_valid || o_out.ready;

    vbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_out_free (out_free),
        .i_status   (dp_status),
        .o_in_ready (i_in.ready),
        .o_emit     (emit),
        .o_cmd      (dp_cmd)
    );

    vbd_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .WINDOW_BITS  (WINDOW_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_data_byte      (i_in.data_byte),
        .i_last_byte      (i_in.last_byte),
        .i_prob           (i_in.prob),
        .i_literal_bits   (i_in.literal_bits),
        .o_status         (dp_status),
        .o_decoded        (dp_decoded),
        .o_range_now      (dp_range_now),
        .o_value_top      (dp_value_top),
        .o_bits_in_byte   (dp_bits_in_byte),
        .o_bytes_consumed (dp_bytes_consumed),
        .o_past_end       (dp_past_end)
    );

    // valid rises on a fresh result, drops once the held one is transferred
    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_decoded        <= dp_decoded;
            r_range_now      <= dp_range_now;
            r_value_top      <= dp_value_top;
            r_bits_in_byte   <= dp_bits_in_byte;
            r_bytes_consumed <= dp_bytes_consumed;
            r_past_end       <= dp_past_end;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.decoded        = r_decoded;
    assign o_out.range_now      = r_range_now;
    assign o_out.value_top      = r_value_top;
    assign o_out.bits_in_byte   = r_bits_in_byte;
    assign o_out.bytes_consumed = r_bytes_consumed;
    assign o_out.past_end       = r_past_end;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for vp8_bool_decoder, with a bit-exact bool decoder predictor
// depends on vbd_pkg, vbd_in_if / vbd_out_if and the vp8_bool_decoder rtl

module tb;
    import vbd_pkg::*;

    localparam int BUF_BYTES        = 2048;
    localparam int WIN_BITS         = 32;
    localparam int CLK_PERIOD       = 12;
    localparam int RANDOM_ITEMS     = 1800;
    localparam int CALM_ITEMS       = 150;      // no idling on either side for the last items
    localparam int HOLD_AFTER       = 200;      // results before the long receiver hold-off
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 64;
    localparam int TIMEOUT_NS       = 25_000_000;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [7:0] prob;
        logic [3:0] lit_bits;
    } t_item;

    typedef struct {
        logic [7:0]  decoded;
        logic [7:0]  range_now;
        logic [7:0]  value_top;
        logic [3:0]  bits_in_byte;
        logic [11:0] bytes_consumed;
        logic        past_end;
    } t_decode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vbd_in_if  in_ch ();
    vbd_out_if out_ch ();

    vp8_bool_decoder #(
        .BUFFER_BYTES (BUF_BYTES),
        .WINDOW_BITS  (WIN_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // stimulus still to be offered, and decode results still owed by the block
    t_item   pending_items [$];
    t_decode exp_decodes [$];

    int mismatches   = 0;
    int results_seen = 0;
    bit offer_taken  = 1'b0;

    // predictor state: value window, signed 7-bit bit count, range, pointers, byte store
    logic [WIN_BITS-1:0] win_q;
    int                  cnt_q;
    logic [7:0]          rng_q;
    int                  rd_pos;
    int                  wr_pos;
    int                  data_len;
    bit                  dry;
    logic [7:0]          store_q [BUF_BYTES];

    // ---------------------------------------------------------------- predictor

    // bit count lives in 7 bits two's complement
    function automatic int wrap_count(int v);
        return (v & 127) - (((v & 64) != 0) ? 128 : 0);
    endfunction

    // bytewise refill; once the data runs short the remaining bytes are taken
    // and the window is marked dry so that no further refill happens
    function automatic void refill_window();
        int          shift;
        int          bits_left;
        int          num;
        int          stop;
        logic [63:0] b;
        shift     = WIN_BITS - 16 - cnt_q;
        bits_left = (data_len > rd_pos) ? (data_len - rd_pos) * 8 : 0;
        num       = shift + 8 - bits_left;
        stop      = 0;
        if (num >= 0) begin
            dry  = 1'b1;
            stop = num;
        end
        if (num < 0 || bits_left != 0) begin
            while (shift >= stop) begin
                b = (rd_pos < BUF_BYTES) ? 64'(store_q[rd_pos]) : 64'd0;
                cnt_q += 8;
                win_q = win_q | WIN_BITS'(b << shift);
                rd_pos++;
                shift -= 8;
            end
        end
        cnt_q = wrap_count(cnt_q);
    endfunction

    // one bool: split the range, pick the bit, renormalise, refill if short
    function automatic logic decode_one(logic [7:0] p);
        int          r;
        int          split;
        int          n;
        logic [63:0] big;
        logic        hit;
        r     = rng_q;
        split = 1 + (((r - 1) * int'(p)) >> 8);
        big   = 64'(split) << (WIN_BITS - 8);
        hit   = (64'(win_q) >= big);
        if (hit) begin
            r     = r - split;
            win_q = win_q - WIN_BITS'(big);
        end else begin
            r = split;
        end
        n = 0;
        while (r < 128 && n < 8) begin
            r = r << 1;
            n++;
        end
        rng_q = r[7:0];
        win_q = win_q << n;
        cnt_q = wrap_count(cnt_q - n);
        if (!dry && cnt_q < 0)
            refill_window();
        return hit;
    endfunction

    // advances the predictor by one accepted item; returns 1 when it owes a result
    function automatic bit predict_item(input t_item it, output t_decode res);
        int         nbits;
        int         i;
        logic [7:0] val;
        bit         produced;
        produced = 1'b0;
        val      = '0;
        res      = '{default: '0};
        case (it.cmd)
            CMD_LOAD: begin
                if (wr_pos < BUF_BYTES) begin
                    store_q[wr_pos] = it.data_byte;
                    wr_pos++;
                end
                if (it.last_byte) begin
                    data_len = wr_pos;
                    wr_pos   = 0;
                end
            end
            CMD_START: begin
                rd_pos = 0;
                win_q  = '0;
                cnt_q  = int'($signed(COUNT_INIT));
                rng_q  = RANGE_INIT;
                dry    = 1'b0;
                refill_window();
            end
            CMD_BOOL: begin
                val      = {7'd0, decode_one(it.prob)};
                produced = 1'b1;
            end
            CMD_LITERAL: begin
                // zero bits decodes nothing, above eight saturates
                nbits = (it.lit_bits > LIT_MAX) ? LIT_MAX : it.lit_bits;
                for (i = 0; i < nbits; i++)
                    val = {val[6:0], decode_one(PROB_HALF)};
                produced = 1'b1;
            end
            default: begin
                produced = 1'b0;
            end
        endcase
        if (produced) begin
            res.decoded        = val;
            res.range_now      = rng_q;
            res.value_top      = win_q[WIN_BITS-1 -: 8];
            res.bits_in_byte   = 4'(BYTE_BITS - (cnt_q & 7));
            res.bytes_consumed = rd_pos[11:0];
            res.past_end       = dry;
        end
        return produced;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // unused fields of an item carry random values too
    function automatic t_item random_fields(t_cmd c);
        t_item it;
        it.cmd       = c;
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom_range(0, 1));
        it.prob      = 8'($urandom);
        it.lit_bits  = 4'($urandom);
        return it;
    endfunction

    function automatic void push_load(logic [7:0] b, logic last);
        t_item it;
        it           = random_fields(CMD_LOAD);
        it.data_byte = b;
        it.last_byte = last;
        pending_items.push_back(it);
    endfunction

    function automatic void push_start();
        pending_items.push_back(random_fields(CMD_START));
    endfunction

    function automatic void push_bool(logic [7:0] p);
        t_item it;
        it      = random_fields(CMD_BOOL);
        it.prob = p;
        pending_items.push_back(it);
    endfunction

    function automatic void push_literal(logic [3:0] n);
        t_item it;
        it          = random_fields(CMD_LITERAL);
        it.lit_bits = n;
        pending_items.push_back(it);
    endfunction

    // the closing stretch of the run goes without idling
    function automatic bit run_calm();
        return pending_items.size() < CALM_ITEMS;
    endfunction

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- input driver

    int send_gap = 0;
    int send_pct = 10;

    // new offer at the falling edge once the previous one has been transferred
    always @(negedge i_clk) begin : drive_items
        t_item it;
        if (i_rst_n && !(in_ch.valid && !offer_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (!run_calm() && $urandom_range(0, 99) < send_pct) begin
                send_gap = $urandom_range(0, 15);
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                in_ch.cmd          <= it.cmd;
                in_ch.data_byte    <= it.data_byte;
                in_ch.last_byte    <= it.last_byte;
                in_ch.prob         <= it.prob;
                in_ch.literal_bits <= it.lit_bits;
                in_ch.valid        <= 1'b1;
                // switch between quiet stretches and bursty ones now and then
                if ($urandom_range(0, 99) == 0)
                    send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result receiver

    int sink_gap  = 0;
    int sink_pct  = 10;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            // one long hold-off so the block fills up and backs up its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (run_calm()) begin
            out_ch.ready <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_pct) begin
            sink_gap = $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                sink_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        end
    end

    // ---------------------------------------------------------------- monitor

    // both channels sampled at the rising edge; input transfers feed the predictor
    always @(posedge i_clk) begin : watch_channels
        t_item   it;
        t_decode res;
        t_decode want;
        offer_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (offer_taken) begin
            it.cmd       = t_cmd'(in_ch.cmd);
            it.data_byte = in_ch.data_byte;
            it.last_byte = in_ch.last_byte;
            it.prob      = in_ch.prob;
            it.lit_bits  = in_ch.literal_bits;
            if (predict_item(it, res))
                exp_decodes.push_back(res);
        end
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            results_seen++;
            if (exp_decodes.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected, actual decoded %0h",
                         $time, out_ch.decoded);
            end else begin
                want = exp_decodes.pop_front();
                check_field("decoded", want.decoded, out_ch.decoded);
                check_field("range_now", want.range_now, out_ch.range_now);
                check_field("value_top", want.value_top, out_ch.value_top);
                check_field("bits_in_byte", want.bits_in_byte, out_ch.bits_in_byte);
                check_field("bytes_consumed", want.bytes_consumed, out_ch.bytes_consumed);
                check_field("past_end", want.past_end, out_ch.past_end);
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run_test
        int base;
        int len;
        int ndec;
        int k;
        int pick;

        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_LOAD;
        in_ch.data_byte    = '0;
        in_ch.last_byte    = 1'b0;
        in_ch.prob         = '0;
        in_ch.literal_bits = '0;
        out_ch.ready       = 1'b0;

        win_q    = '0;
        cnt_q    = int'($signed(COUNT_INIT));
        rng_q    = RANGE_INIT;
        rd_pos   = 0;
        wr_pos   = 0;
        data_len = 0;
        dry      = 1'b0;
        foreach (store_q[i])
            store_q[i] = '0;

        // directed: decoding straight out of reset, on an empty window
        push_bool(8'h00);
        push_literal(4'd0);
        push_literal(4'd15);
        // a partition long enough that start does not run dry
        push_load(8'hFF, 1'b0);
        push_load(8'h00, 1'b0);
        push_load(8'hA5, 1'b0);
        push_load(8'h5A, 1'b0);
        push_load(8'h80, 1'b0);
        push_load(8'h7F, 1'b0);
        push_load(8'h01, 1'b0);
        push_load(8'hFE, 1'b1);
        push_start();
        push_bool(8'h00);
        push_bool(8'hFF);
        push_bool(PROB_HALF);
        push_literal(LIT_MAX);
        push_literal(4'd1);
        // shrink the data length under the read position mid-stream
        push_load(8'h3C, 1'b1);
        push_literal(LIT_MAX);
        push_literal(4'd9);
        push_literal(4'd0);
        push_bool(8'h01);

        // random: mostly load/start/decode sequences, with stray loads and restarts,
        // and some bursts of arbitrary items
        base = pending_items.size();
        while (pending_items.size() - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 88) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    push_load(8'($urandom), k == len - 1);
                push_start();
                ndec = $urandom_range(1, 3 * len + 4);
                for (k = 0; k < ndec; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        push_bool(($urandom_range(0, 7) == 0)
                                  ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                  : 8'($urandom));
                    else if (pick < 92)
                        push_literal(($urandom_range(0, 7) == 0) ? 4'($urandom)
                                                                 : 4'($urandom_range(1, 8)));
                    else if (pick < 97)
                        push_load(8'($urandom), 1'($urandom_range(0, 1)));
                    else
                        push_start();
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    pending_items.push_back(random_fields(t_cmd'($urandom_range(0, 3))));
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || exp_decodes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
